// ===== hdl/dbsf_pkg.sv =====
package dbsf_pkg;

  // Item kinds carried on in_tuser
  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_XLATE = 2'd1,
    FN_NEXT  = 2'd2
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DIRECT = 2'd0,
    ST_FWD    = 2'd1,
    ST_RANGE  = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_RMW,
    S_SRCH
  } state_t;

  // Field widths fixed by the bus layout
  localparam int DRIVE_W = 3;
  localparam int IDX_W   = 4;
  localparam int BLK_W   = 16;
  localparam int CNT_W   = 8;
  localparam int CYL_W   = 10;
  localparam int TRK_W   = 2;
  localparam int SEC_W   = 5;
  // one table entry in a row: valid, cylinder, track, sector
  localparam int ENT_W   = 1 + CYL_W + TRK_W + SEC_W;
  // slot number wide enough for up to 32 slots
  localparam int SLOT_W  = 5;

  typedef struct packed {
    func_t                func;
    logic [DRIVE_W-1:0]   drive;
    logic [IDX_W-1:0]     idx;
    logic                 valid;
    logic [BLK_W-1:0]     blk;
    logic [CNT_W-1:0]     cnt;
    logic                 is_read;
    logic [CYL_W-1:0]     cyl;
    logic [TRK_W-1:0]     trk;
    logic [SEC_W-1:0]     sec;
  } item_t;

  typedef struct packed {
    status_t              status;
    logic [CYL_W-1:0]     cyl;
    logic [TRK_W-1:0]     trk;
    logic [SEC_W-1:0]     sec;
    logic [IDX_W-1:0]     spare;
  } res_t;

  // Control from the sequencer to the datapath
  typedef struct packed {
    logic accept;
    logic ram_re;
    logic in_rmw;
    logic in_srch;
  } ctrl_t;

endpackage

// ===== hdl/dbsf_ram.sv =====
module dbsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read that holds between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/disk_bad_sector_forwarding.sv =====
// Order: load, advance, unused kinds and out-of-range translates reach the result
// register from S_RMW after accept; an in-range translate adds the S_SRCH row compare.
// Flow: one item at a time; a new beat is taken in the cycle its result leaves, and a
// stalled receiver holds the input.
// Reset: synchronous active-low; all drive tables read as empty, output channel idle.
// The row memory itself is not cleared: a per-drive written flag masks stale rows.
module disk_bad_sector_forwarding #(
  parameter int DRIVES        = 8,
  parameter int TABLE_ENTRIES = 10,
  parameter int CYLINDERS     = 815,
  parameter int TRACKS        = 3,
  parameter int SECTORS       = 22
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // drive[2:0] entry_index[6:3] entry_valid[7] block[23:8] sector_count[31:24]
  // is_read[32] cyl_in[42:33] track_in[44:43] sector_in[49:45], zero above
  input  logic [55:0] in_tdata,
  // func[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0] cyl_out[11:2] track_out[13:12] sector_out[18:14]
  // spare_index[22:19], zero above
  output logic [23:0] out_tdata
);

  import dbsf_pkg::*;

  localparam int AW     = (DRIVES > 1) ? $clog2(DRIVES) : 1;
  localparam int ROW_W  = TABLE_ENTRIES * ENT_W;
  localparam int TS     = TRACKS * SECTORS;
  // reciprocal constants: floor(x/D) = (x*M) >> K, exact for 16-bit x
  localparam int KS     = BLK_W + $clog2(SECTORS);
  localparam int KC     = BLK_W + $clog2(TS);
  localparam longint unsigned MS = ((64'd1 << KS) + SECTORS - 1) / SECTORS;
  localparam longint unsigned MC = ((64'd1 << KC) + TS - 1) / TS;
  localparam int PACK_BLOCKS  = CYLINDERS * TRACKS * SECTORS;
  localparam int WRITE_BLOCKS = (CYLINDERS - 1) * TRACKS * SECTORS;

  state_t              state_r, state_nxt;
  ctrl_t               ctl;
  item_t               in_item;
  item_t               item_r;
  logic [BLK_W-1:0]    qs_r, qc_r;
  logic [47:0]         prod_s, prod_c;
  logic [SEC_W-1:0]    s_r, s_nxt;
  logic [3:0]          t_r, t_nxt;
  logic [BLK_W-1:0]    s_full, t_full;
  logic [2**AW-1:0]    row_wr_r;
  logic [AW+DRIVE_W-1:0] in_drv_ext, it_drv_ext;
  logic [AW-1:0]       rd_addr, it_addr;
  logic                drive_ok, idx_ok, oor, search_en;
  logic                ram_we;
  logic [ROW_W-1:0]    ram_rdata, row_cur, row_new;
  logic [BLK_W:0]      run_end;
  logic                out_valid_r, out_valid_nxt;
  res_t                res_r, res_nxt;
  logic                res_load;

  // unpack the input beat
  assign in_item.func    = func_t'(in_tuser);
  assign in_item.drive   = in_tdata[2:0];
  assign in_item.idx     = in_tdata[6:3];
  assign in_item.valid   = in_tdata[7];
  assign in_item.blk     = in_tdata[23:8];
  assign in_item.cnt     = in_tdata[31:24];
  assign in_item.is_read = in_tdata[32];
  assign in_item.cyl     = in_tdata[42:33];
  assign in_item.trk     = in_tdata[44:43];
  assign in_item.sec     = in_tdata[49:45];

  assign in_drv_ext = (AW+DRIVE_W)'(in_item.drive);
  assign rd_addr    = in_drv_ext[AW-1:0];
  assign it_drv_ext = (AW+DRIVE_W)'(item_r.drive);
  assign it_addr    = it_drv_ext[AW-1:0];
  assign drive_ok   = 32'(item_r.drive) < DRIVES;
  assign idx_ok     = 32'(item_r.idx) < TABLE_ENTRIES;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (ctl.accept) state_nxt = S_RMW;
      S_RMW: begin
        if (item_r.func == FN_XLATE && !oor) state_nxt = S_SRCH;
        else state_nxt = S_IDLE;
      end
      S_SRCH: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctl = '0;
    unique case (state_r)
      S_IDLE: begin
        in_tready  = !out_valid_r || out_tready;
        ctl.accept = in_tvalid && in_tready;
        ctl.ram_re = ctl.accept;
      end
      S_RMW: begin
        in_tready  = 1'b0;
        ctl.in_rmw = 1'b1;
      end
      S_SRCH: begin
        in_tready   = 1'b0;
        ctl.in_srch = 1'b1;
      end
      default: in_tready = 1'b0;
    endcase
  end

  // one row per drive: all table entries side by side
  dbsf_ram #(
    .WIDTH(ROW_W),
    .DEPTH(DRIVES)
  ) u_rows (
    .clk  (clk),
    .we   (ram_we),
    .waddr(it_addr),
    .wdata(row_new),
    .re   (ctl.ram_re),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  // quotients by sectors and by sectors per cylinder, taken at accept
  assign prod_s = 48'(in_item.blk) * 48'(MS);
  assign prod_c = 48'(in_item.blk) * 48'(MC);

  // remainders: sector and track
  assign s_full = item_r.blk - BLK_W'(32'(qs_r) * SECTORS);
  assign t_full = qs_r - BLK_W'(32'(qc_r) * TRACKS);
  assign s_nxt  = s_full[SEC_W-1:0];
  assign t_nxt  = t_full[3:0];

  // range check of the run
  assign run_end = (BLK_W+1)'(item_r.blk) + (BLK_W+1)'(item_r.cnt);
  always_comb begin
    if (item_r.is_read) oor = 32'(run_end) > PACK_BLOCKS;
    else oor = 32'(run_end) > WRITE_BLOCKS;
  end

  // read-modify-write of one entry for a load
  assign row_cur = row_wr_r[it_addr] ? ram_rdata : '0;
  assign ram_we  = ctl.in_rmw && item_r.func == FN_LOAD && drive_ok && idx_ok;
  always_comb begin
    row_new = row_cur;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (32'(item_r.idx) == i) begin
        row_new[i*ENT_W +: ENT_W] = {item_r.valid, item_r.cyl, item_r.trk, item_r.sec};
      end
    end
  end

  assign search_en = drive_ok && row_wr_r[it_addr];

  // result for each kind
  always_comb begin
    logic [SEC_W:0]   sec_inc;
    logic [TRK_W:0]   trk_inc;
    logic [ENT_W-1:0] ent;
    logic             alive, found;
    logic [SLOT_W-1:0] hit;
    res_nxt  = '0;
    res_load = 1'b0;
    sec_inc  = (SEC_W+1)'(item_r.sec) + 1'b1;
    trk_inc  = (TRK_W+1)'(item_r.trk) + 1'b1;
    alive    = 1'b1;
    found    = 1'b0;
    hit      = '0;
    ent      = '0;
    if (ctl.in_rmw) begin
      case (item_r.func)
        FN_NEXT: begin
          res_load = 1'b1;
          res_nxt.cyl = item_r.cyl;
          res_nxt.trk = item_r.trk;
          res_nxt.sec = sec_inc[SEC_W-1:0];
          if (32'(sec_inc) >= SECTORS) begin
            res_nxt.sec = '0;
            res_nxt.trk = trk_inc[TRK_W-1:0];
            if (32'(trk_inc) >= TRACKS) begin
              res_nxt.trk = '0;
              res_nxt.cyl = item_r.cyl + 1'b1;
            end
          end
        end
        FN_XLATE: begin
          // in-range runs go on to the table search
          if (oor) begin
            res_load = 1'b1;
            res_nxt.status = ST_RANGE;
          end
        end
        default: res_load = 1'b1;
      endcase
    end else if (ctl.in_srch) begin
      res_load = 1'b1;
      // walk the row in slot order, stop at the first match or the first empty slot
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        ent = ram_rdata[i*ENT_W +: ENT_W];
        if (alive && !found) begin
          if (!(ent[ENT_W-1] && search_en)) begin
            alive = 1'b0;
          end else if (ent[ENT_W-2 -: CYL_W] == qc_r[CYL_W-1:0] &&
                       ent[TRK_W+SEC_W-1:0] == {t_r[TRK_W-1:0], s_r}) begin
            found = 1'b1;
            hit   = SLOT_W'(i);
          end
        end
      end
      if (found) begin
        res_nxt.status = ST_FWD;
        res_nxt.cyl    = CYL_W'(CYLINDERS - 1);
        res_nxt.sec    = hit;
        res_nxt.spare  = hit[IDX_W-1:0];
      end else begin
        res_nxt.cyl = qc_r[CYL_W-1:0];
        res_nxt.trk = t_r[TRK_W-1:0];
        res_nxt.sec = s_r;
      end
    end
  end

  assign out_valid_nxt = res_load ? 1'b1 : (out_valid_r && !out_tready);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      row_wr_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_we) row_wr_r[it_addr] <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      item_r <= in_item;
      qs_r   <= prod_s[KS +: BLK_W];
      qc_r   <= prod_c[KC +: BLK_W];
    end
    if (ctl.in_rmw) begin
      s_r <= s_nxt;
      t_r <= t_nxt;
    end
    if (res_load) res_r <= res_nxt;
  end

  // pack the result beat
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r.spare, res_r.sec, res_r.trk, res_r.cyl, res_r.status};

endmodule

// ===== sim/tb_disk_bad_sector_forwarding.sv =====
module tb_disk_bad_sector_forwarding;
  timeunit 1ns;
  timeprecision 1ps;

  import dbsf_pkg::*;

  localparam int DRIVES        = 8;
  localparam int TABLE_ENTRIES = 10;
  localparam int CYLINDERS     = 815;
  localparam int TRACKS        = 3;
  localparam int SECTORS       = 22;
  localparam int SLOTS         = DRIVES * TABLE_ENTRIES;
  localparam int CYL_BLOCKS    = TRACKS * SECTORS;
  localparam int PACK_BLOCKS   = CYLINDERS * CYL_BLOCKS;
  localparam int WRITE_BLOCKS  = (CYLINDERS - 1) * CYL_BLOCKS;
  localparam int REPAIR_CYL    = CYLINDERS - 1;
  localparam int PHASE_BEATS   = 300;

  // tuser code that the block does not define
  localparam func_t FN_UNUSED = func_t'(2'd3);

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  disk_bad_sector_forwarding #(
    .DRIVES       (DRIVES),
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .CYLINDERS    (CYLINDERS),
    .TRACKS       (TRACKS),
    .SECTORS      (SECTORS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the bad-sector tables
  logic             tab_valid [SLOTS];
  logic [CYL_W-1:0] tab_cyl   [SLOTS];
  logic [TRK_W-1:0] tab_trk   [SLOTS];
  logic [SEC_W-1:0] tab_sec   [SLOTS];
  int               fill_ptr  [DRIVES];

  res_t mapped_q [$];
  res_t head_res;
  int   err_cnt = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  // Directed rows: item fields, then the result typed in by hand, used where the
  // last column is set; other rows go through the predictor
  typedef struct {
    func_t            fn;
    logic [2:0]       drv;
    logic [3:0]       idx;
    logic             vld;
    logic [15:0]      blk;
    logic [7:0]       cnt;
    logic             rd;
    logic [CYL_W-1:0] cyl;
    logic [TRK_W-1:0] trk;
    logic [SEC_W-1:0] sec;
    status_t          st;
    logic [CYL_W-1:0] e_cyl;
    logic [TRK_W-1:0] e_trk;
    logic [SEC_W-1:0] e_sec;
    logic [IDX_W-1:0] e_spare;
    bit               hand;
  } dir_row_t;

  localparam int DIR_N = 25;
  dir_row_t dir_tab [DIR_N] = '{
    // empty tables, range limits for read and write
    '{FN_XLATE, 0, 0,  0, 0,     1,   1, 0,    0, 0,  ST_DIRECT, 0,   0, 0, 0, 1},
    '{FN_XLATE, 0, 0,  0, 53790, 0,   1, 0,    0, 0,  ST_DIRECT, 815, 0, 0, 0, 1},
    '{FN_XLATE, 0, 0,  0, 53790, 1,   1, 0,    0, 0,  ST_RANGE,  0,   0, 0, 0, 1},
    '{FN_XLATE, 0, 0,  0, 53724, 0,   0, 0,    0, 0,  ST_DIRECT, 814, 0, 0, 0, 1},
    '{FN_XLATE, 0, 0,  0, 53724, 1,   0, 0,    0, 0,  ST_RANGE,  0,   0, 0, 0, 1},
    '{FN_XLATE, 7, 0,  0, 65535, 255, 0, 0,    0, 0,  ST_RANGE,  0,   0, 0, 0, 1},
    // bad sector on cylinder 815, one past the last, reached by an empty read at the pack limit
    '{FN_LOAD,  0, 0,  1, 0,     0,   0, 815,  0, 0,  ST_DIRECT, 0,   0, 0, 0, 1},
    '{FN_XLATE, 0, 0,  0, 53790, 0,   1, 0,    0, 0,  ST_DIRECT, 0,   0, 0, 0, 0},
    // fill drive 7 completely: slot i holds cylinder i, track 2, sector 21
    '{FN_LOAD,  7, 0,  1, 0,     0,   0, 0,    2, 21, ST_DIRECT, 0,   0, 0, 0, 1},
    '{FN_LOAD,  7, 1,  1, 0,     0,   0, 1,    2, 21, ST_DIRECT, 0,   0, 0, 0, 1},
    '{FN_LOAD,  7, 2,  1, 0,     0,   0, 2,    2, 21, ST_DIRECT, 0,   0, 0, 0, 1},
    '{FN_LOAD,  7, 3,  1, 0,     0,   0, 3,    2, 21, ST_DIRECT, 0,   0, 0, 0, 1},
    '{FN_LOAD,  7, 4,  1, 0,     0,   0, 4,    2, 21, ST_DIRECT, 0,   0, 0, 0, 1},
    '{FN_LOAD,  7, 5,  1, 0,     0,   0, 5,    2, 21, ST_DIRECT, 0,   0, 0, 0, 1},
    '{FN_LOAD,  7, 6,  1, 0,     0,   0, 6,    2, 21, ST_DIRECT, 0,   0, 0, 0, 1},
    '{FN_LOAD,  7, 7,  1, 0,     0,   0, 7,    2, 21, ST_DIRECT, 0,   0, 0, 0, 1},
    '{FN_LOAD,  7, 8,  1, 0,     0,   0, 8,    2, 21, ST_DIRECT, 0,   0, 0, 0, 1},
    '{FN_LOAD,  7, 9,  1, 0,     0,   0, 9,    2, 21, ST_DIRECT, 0,   0, 0, 0, 1},
    // hit in the last slot, then a miss that runs off the end of a full table
    '{FN_XLATE, 7, 0,  0, 659,   0,   1, 0,    0, 0,  ST_DIRECT, 0,   0, 0, 0, 0},
    '{FN_XLATE, 7, 0,  0, 0,     128, 0, 0,    0, 0,  ST_DIRECT, 0,   0, 0, 0, 1},
    // slot index past the table is dropped, so drive 0 still forwards
    '{FN_LOAD,  0, 15, 0, 0,     0,   0, 0,    0, 0,  ST_DIRECT, 0,   0, 0, 0, 1},
    '{FN_XLATE, 0, 0,  0, 53790, 0,   1, 0,    0, 0,  ST_DIRECT, 0,   0, 0, 0, 0},
    // advance with full wrap, and from out-of-range track and sector
    '{FN_NEXT,  0, 0,  0, 0,     0,   0, 1023, 2, 21, ST_DIRECT, 0,   0, 0, 0, 1},
    '{FN_NEXT,  0, 0,  0, 0,     0,   0, 5,    3, 31, ST_DIRECT, 6,   0, 0, 0, 1},
    '{FN_UNUSED, 7, 15, 1, 65535, 255, 1, 1023, 3, 31, ST_DIRECT, 0,  0, 0, 0, 1}
  };

  function automatic logic [55:0] pack_item(input item_t it);
    return {6'd0, it.sec, it.trk, it.cyl, it.is_read, it.cnt, it.blk, it.valid,
            it.idx, it.drive};
  endfunction

  // Expected result of one beat; loads also update the shadow tables
  function automatic res_t map_item(input item_t it);
    res_t        r;
    int unsigned lim, c, t, s, slot, i;
    bit          stop;
    r = '0;
    case (it.func)
      FN_LOAD: begin
        if (it.idx < TABLE_ENTRIES) begin
          slot = it.drive * TABLE_ENTRIES + it.idx;
          tab_valid[slot] = it.valid;
          tab_cyl[slot]   = it.cyl;
          tab_trk[slot]   = it.trk;
          tab_sec[slot]   = it.sec;
        end
      end
      FN_XLATE: begin
        lim = it.is_read ? PACK_BLOCKS : WRITE_BLOCKS;
        c = 32'(it.blk);
        t = 32'(it.cnt);
        if (c + t > lim) begin
          r.status = ST_RANGE;
        end else begin
          c = it.blk / CYL_BLOCKS;
          t = (it.blk / SECTORS) % TRACKS;
          s = it.blk % SECTORS;
          r.cyl = c[CYL_W-1:0];
          r.trk = t[TRK_W-1:0];
          r.sec = s[SEC_W-1:0];
          // first-fit search, ends at the first empty slot
          stop = 1'b0;
          for (i = 0; i < TABLE_ENTRIES && !stop; i++) begin
            slot = it.drive * TABLE_ENTRIES + i;
            if (!tab_valid[slot]) begin
              stop = 1'b1;
            end else if (tab_cyl[slot] == c[CYL_W-1:0] && tab_trk[slot] == t[TRK_W-1:0] &&
                         tab_sec[slot] == s[SEC_W-1:0]) begin
              r.status = ST_FWD;
              r.cyl    = CYL_W'(REPAIR_CYL);
              r.trk    = '0;
              r.sec    = i[SEC_W-1:0];
              r.spare  = i[IDX_W-1:0];
              stop     = 1'b1;
            end
          end
        end
      end
      FN_NEXT: begin
        c = 32'(it.cyl);
        t = 32'(it.trk);
        s = it.sec + 1;
        if (s >= SECTORS) begin
          s = 0;
          t = t + 1;
          if (t >= TRACKS) begin
            t = 0;
            c = c + 1;
          end
        end
        r.cyl = c[CYL_W-1:0];
        r.trk = t[TRK_W-1:0];
        r.sec = s[SEC_W-1:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  // Random beat: mostly table fills and lookups aimed at loaded bad sectors
  function automatic item_t make_item();
    item_t       it;
    int unsigned r, slot, b;
    it.drive   = DRIVE_W'($urandom_range(DRIVES - 1));
    it.idx     = IDX_W'($urandom_range(15));
    it.valid   = 1'($urandom_range(1));
    it.blk     = BLK_W'($urandom_range(16'hffff));
    it.cnt     = CNT_W'($urandom_range(8'hff));
    it.is_read = 1'($urandom_range(1));
    it.cyl     = CYL_W'($urandom_range(10'h3ff));
    it.trk     = TRK_W'($urandom_range(3));
    it.sec     = SEC_W'($urandom_range(31));
    r = $urandom_range(99);
    if (r < 30) begin
      it.func = FN_LOAD;
      if ($urandom_range(99) < 8) begin
        it.idx = IDX_W'($urandom_range(15, TABLE_ENTRIES));
      end else begin
        it.idx = IDX_W'(fill_ptr[it.drive]);
        fill_ptr[it.drive] = (fill_ptr[it.drive] + 1) % TABLE_ENTRIES;
      end
      it.valid = ($urandom_range(9) != 0);
      if ($urandom_range(99) < 85) begin
        it.cyl = CYL_W'($urandom_range(CYLINDERS));
        it.trk = TRK_W'($urandom_range(TRACKS - 1));
        it.sec = SEC_W'($urandom_range(SECTORS - 1));
      end
    end else if (r < 75) begin
      it.func = FN_XLATE;
      if ($urandom_range(99) < 70) it.cnt = CNT_W'($urandom_range(128));
      r = $urandom_range(99);
      slot = it.drive * TABLE_ENTRIES + $urandom_range(TABLE_ENTRIES - 1);
      if (r < 55) begin
        b = tab_cyl[slot] * CYL_BLOCKS + tab_trk[slot] * SECTORS + tab_sec[slot];
        if (tab_valid[slot] && tab_trk[slot] < TRACKS && tab_sec[slot] < SECTORS &&
            b <= 16'hffff)
          it.blk = BLK_W'(b);
        else
          it.blk = BLK_W'($urandom_range(PACK_BLOCKS));
      end else if (r < 75) begin
        // straddle the read and write limits
        it.blk = BLK_W'(PACK_BLOCKS - $urandom_range(300));
      end else if (r < 90) begin
        it.blk = BLK_W'($urandom_range(PACK_BLOCKS));
      end
    end else if (r < 93) begin
      it.func = FN_NEXT;
      r = $urandom_range(99);
      if (r < 50) begin
        it.cyl = CYL_W'($urandom_range(CYLINDERS - 1));
        it.trk = TRK_W'($urandom_range(TRACKS - 1));
        it.sec = SEC_W'($urandom_range(SECTORS - 1));
      end else if (r < 75) begin
        it.trk = TRK_W'(TRACKS - 1);
        it.sec = SEC_W'(SECTORS - 1);
      end
    end else begin
      it.func = FN_UNUSED;
    end
    return it;
  endfunction

  // Present one beat from a falling edge and queue its result once taken
  task automatic send_item(input item_t it, input bit typed, input res_t typed_res);
    res_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_item(it);
    in_tuser  <= it.func;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = map_item(it);
    mapped_q.push_back(typed ? typed_res : want);
    @(negedge clk);
  endtask

  // Hold off the sender until every result is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (mapped_q.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (mapped_q.size() == 0) begin
        $display("%0t ns: result beat with nothing outstanding, expected none, got %h",
                 $time, out_tdata);
        err_cnt++;
      end else begin
        head_res = mapped_q.pop_front();
        check_field("status",      16'(head_res.status), 16'(out_tdata[1:0]));
        check_field("cyl_out",     16'(head_res.cyl),    16'(out_tdata[11:2]));
        check_field("track_out",   16'(head_res.trk),    16'(out_tdata[13:12]));
        check_field("sector_out",  16'(head_res.sec),    16'(out_tdata[18:14]));
        check_field("spare_index", 16'(head_res.spare),  16'(out_tdata[22:19]));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    item_t it;
    res_t  typed_res;
    for (int i = 0; i < SLOTS; i++) begin
      tab_valid[i] = 1'b0;
      tab_cyl[i]   = '0;
      tab_trk[i]   = '0;
      tab_sec[i]   = '0;
    end
    for (int d = 0; d < DRIVES; d++) fill_ptr[d] = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table, no idling
    foreach (dir_tab[n]) begin
      it.func    = dir_tab[n].fn;
      it.drive   = dir_tab[n].drv;
      it.idx     = dir_tab[n].idx;
      it.valid   = dir_tab[n].vld;
      it.blk     = dir_tab[n].blk;
      it.cnt     = dir_tab[n].cnt;
      it.is_read = dir_tab[n].rd;
      it.cyl     = dir_tab[n].cyl;
      it.trk     = dir_tab[n].trk;
      it.sec     = dir_tab[n].sec;
      typed_res.status = dir_tab[n].st;
      typed_res.cyl    = dir_tab[n].e_cyl;
      typed_res.trk    = dir_tab[n].e_trk;
      typed_res.sec    = dir_tab[n].e_sec;
      typed_res.spare  = dir_tab[n].e_spare;
      send_item(it, dir_tab[n].hand, typed_res);
    end
    drain_results();

    // random phases: free flow, idle sender, stalling receiver, light on both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      repeat (PHASE_BEATS) send_item(make_item(), 1'b0, '0);
      drain_results();
    end

    // allow for a stray late beat
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
